@@ hdl/mca_pkg.sv @@
`default_nettype none

package mca_pkg;

  localparam int PIX_W = 8;
  // sum of three 8x8 products, max 3*255*255
  localparam int DOT_W = 18;
  localparam int MSQ_W = 18;
  // 255*dot and alpha*msq both stay below 2^26
  localparam int NUM_W = 26;
  localparam int DEN_W = 26;
  // dividend 255*(den-num) < 256*den
  localparam int REM_W = DEN_W + 8;
  localparam int Q_W = 8;
  localparam int N_CELLS = Q_W;
  // accept edge to the edge at which the result transfers
  localparam int LATENCY = 4 + N_CELLS;

  localparam logic [PIX_W-1:0] MATTE_RED_RST = 8'd255;
  localparam logic [PIX_W-1:0] MATTE_GREEN_RST = 8'd241;
  localparam logic [PIX_W-1:0] MATTE_BLUE_RST = 8'd150;
  localparam logic [PIX_W-1:0] MATTE_ALPHA_RST = 8'd255;
  localparam logic [MSQ_W-1:0] MSQ_RST = MSQ_W'(255 * 255 + 241 * 241 + 150 * 150);

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    REG_RED   = 2'd0,
    REG_GREEN = 2'd1,
    REG_BLUE  = 2'd2,
    REG_ALPHA = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_blue;
    logic [PIX_W-1:0] pixel_green;
    logic [PIX_W-1:0] pixel_red;
    logic [PIX_W-1:0] pixel_alpha;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_alpha;
    logic             keyed_out;
  } out_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] alpha;
  } matte_t;

  typedef struct packed {
    logic valid;
    logic keyed;
    logic zero;
  } ctl_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [Q_W-1:0]   quo;
  } div_t;

endpackage

`default_nettype wire

@@ hdl/mca_prep.sv @@
`default_nettype none

module mca_prep (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     take_i,
  input  wire mca_pkg::in_item_t        item_i,
  input  wire mca_pkg::matte_t          matte_i,
  input  wire logic [mca_pkg::MSQ_W-1:0] msq_i,
  output mca_pkg::ctl_t                 ctl_o,
  output mca_pkg::div_t                 div_o
);

  // stage A: dot product and key test
  logic [15:0] prod_b, prod_g, prod_r;
  logic        keyed;
  mca_pkg::ctl_t             a_ctl_r;
  logic [mca_pkg::DOT_W-1:0] a_dot_r;
  logic [mca_pkg::PIX_W-1:0] a_alpha_r;

  assign prod_b = 16'(item_i.pixel_blue) * 16'(matte_i.blue);
  assign prod_g = 16'(item_i.pixel_green) * 16'(matte_i.green);
  assign prod_r = 16'(item_i.pixel_red) * 16'(matte_i.red);
  assign keyed = (item_i.pixel_alpha == '0) ||
                 (item_i.pixel_red == matte_i.red && item_i.pixel_green == matte_i.green &&
                  item_i.pixel_blue == matte_i.blue && item_i.pixel_alpha == matte_i.alpha);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_ctl_r <= '0;
    end else begin
      a_ctl_r <= '{valid: take_i, keyed: keyed, zero: 1'b0};
    end
    a_dot_r <= mca_pkg::DOT_W'(prod_b) + mca_pkg::DOT_W'(prod_g) + mca_pkg::DOT_W'(prod_r);
    a_alpha_r <= item_i.pixel_alpha;
  end

  // stage B: numerator 255*dot by shift-subtract, denominator alpha*msq
  mca_pkg::ctl_t             b_ctl_r;
  logic [mca_pkg::NUM_W-1:0] b_num_r;
  logic [mca_pkg::DEN_W-1:0] b_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_ctl_r <= '0;
    end else begin
      b_ctl_r <= a_ctl_r;
    end
    b_num_r <= (mca_pkg::NUM_W'(a_dot_r) << 8) - mca_pkg::NUM_W'(a_dot_r);
    b_den_r <= mca_pkg::DEN_W'(a_alpha_r) * mca_pkg::DEN_W'(msq_i);
  end

  // stage C: black matte or projection past the matte gives zero
  mca_pkg::ctl_t             c_ctl_r;
  logic [mca_pkg::DEN_W-1:0] c_diff_r;
  logic [mca_pkg::DEN_W-1:0] c_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_ctl_r <= '0;
    end else begin
      c_ctl_r <= '{valid: b_ctl_r.valid, keyed: b_ctl_r.keyed,
                   zero: (b_den_r == '0) || (mca_pkg::DEN_W'(b_num_r) >= b_den_r)};
    end
    c_diff_r <= b_den_r - mca_pkg::DEN_W'(b_num_r);
    c_den_r <= b_den_r;
  end

  // stage D: dividend 255*(den-num)
  mca_pkg::ctl_t d_ctl_r;
  mca_pkg::div_t d_div_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_ctl_r <= '0;
    end else begin
      d_ctl_r <= c_ctl_r;
    end
    d_div_r <= '{rem: (mca_pkg::REM_W'(c_diff_r) << 8) - mca_pkg::REM_W'(c_diff_r),
                 den: c_den_r,
                 quo: '0};
  end

  assign ctl_o = d_ctl_r;
  assign div_o = d_div_r;

endmodule

`default_nettype wire

@@ hdl/mca_div_cell.sv @@
`default_nettype none

module mca_div_cell (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire mca_pkg::ctl_t ctl_i,
  input  wire mca_pkg::div_t div_i,
  output mca_pkg::ctl_t      ctl_o,
  output mca_pkg::div_t      div_o
);

  // One quotient bit per cell, MSB first. The remainder is compared against
  // den*128 every time and shifted left instead of shifting the divisor.
  logic [mca_pkg::REM_W-1:0] den_hi;
  logic [mca_pkg::REM_W-1:0] rem_sub;
  logic                      ge;
  mca_pkg::ctl_t             ctl_r;
  mca_pkg::div_t             div_r, div_nxt;

  assign den_hi = mca_pkg::REM_W'({div_i.den, 7'b0});
  assign ge = div_i.rem >= den_hi;
  assign rem_sub = ge ? (div_i.rem - den_hi) : div_i.rem;

  always_comb begin
    div_nxt.rem = rem_sub << 1;
    div_nxt.den = div_i.den;
    div_nxt.quo = {div_i.quo[mca_pkg::Q_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_i;
    end
    div_r <= div_nxt;
  end

  assign ctl_o = ctl_r;
  assign div_o = div_r;

endmodule

`default_nettype wire

@@ hdl/matte_color_to_alpha_top.sv @@
`default_nettype none

// Matte color to alpha.
// Input: a premultiplied BGRA pixel on in_item transfers at a rising edge
// with start high and busy low. busy stays low, so one pixel can be taken
// every cycle and many pixels are in flight at once.
// Output: one result per pixel, shown on out_item for a single cycle with
// out_valid high; results transfer in input order.
// The receiver cannot stall; results are taken as they come.
// Throughput is one pixel per cycle. The pipeline is 4 prep stages (products,
// numerator/denominator, zero test, dividend) plus a chain of 8 divider
// cells, each resolving one bit of the alpha quotient.
// Configuration: APB-style port, matte_red/green/blue/alpha at byte
// addresses 0x0/0x4/0x8/0xC, bits [7:0]. Write only while no pixel is in
// flight. pready is always high.
// Reset (rst_n low, synchronous) empties the pipeline and loads the
// default matte 255/241/150/255.
module matte_color_to_alpha_top (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire mca_pkg::in_item_t            in_item,
  output logic                              out_valid,
  output mca_pkg::out_item_t                out_item,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [mca_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [mca_pkg::DATA_W-1:0]   pwdata,
  output logic [mca_pkg::DATA_W-1:0]        prdata,
  output logic                              pready
);

  mca_pkg::matte_t           matte_r;
  logic [mca_pkg::MSQ_W-1:0] msq_r;
  mca_pkg::reg_idx_t         reg_idx;
  logic                      cfg_wr;
  logic [15:0]               sq_r, sq_g, sq_b;

  assign busy = 1'b0;
  assign pready = 1'b1;
  assign reg_idx = mca_pkg::reg_idx_t'(paddr[3:2]);
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      matte_r.red <= mca_pkg::MATTE_RED_RST;
      matte_r.green <= mca_pkg::MATTE_GREEN_RST;
      matte_r.blue <= mca_pkg::MATTE_BLUE_RST;
      matte_r.alpha <= mca_pkg::MATTE_ALPHA_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        mca_pkg::REG_RED:   matte_r.red <= pwdata[7:0];
        mca_pkg::REG_GREEN: matte_r.green <= pwdata[7:0];
        mca_pkg::REG_BLUE:  matte_r.blue <= pwdata[7:0];
        mca_pkg::REG_ALPHA: matte_r.alpha <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      mca_pkg::REG_RED:   prdata = mca_pkg::DATA_W'(matte_r.red);
      mca_pkg::REG_GREEN: prdata = mca_pkg::DATA_W'(matte_r.green);
      mca_pkg::REG_BLUE:  prdata = mca_pkg::DATA_W'(matte_r.blue);
      mca_pkg::REG_ALPHA: prdata = mca_pkg::DATA_W'(matte_r.alpha);
      default:            prdata = '0;
    endcase
  end

  // squared matte length, registered, so it follows the matte registers in the next cycle
  assign sq_r = 16'(matte_r.red) * 16'(matte_r.red);
  assign sq_g = 16'(matte_r.green) * 16'(matte_r.green);
  assign sq_b = 16'(matte_r.blue) * 16'(matte_r.blue);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      msq_r <= mca_pkg::MSQ_RST;
    end else begin
      msq_r <= mca_pkg::MSQ_W'(sq_r) + mca_pkg::MSQ_W'(sq_g) + mca_pkg::MSQ_W'(sq_b);
    end
  end

  mca_pkg::ctl_t ctl_chain [mca_pkg::N_CELLS+1];
  mca_pkg::div_t div_chain [mca_pkg::N_CELLS+1];

  mca_prep u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .take_i  (start && !busy),
    .item_i  (in_item),
    .matte_i (matte_r),
    .msq_i   (msq_r),
    .ctl_o   (ctl_chain[0]),
    .div_o   (div_chain[0])
  );

  for (genvar i = 0; i < mca_pkg::N_CELLS; i++) begin : g_cell
    mca_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl_i (ctl_chain[i]),
      .div_i (div_chain[i]),
      .ctl_o (ctl_chain[i+1]),
      .div_o (div_chain[i+1])
    );
  end

  assign out_valid = ctl_chain[mca_pkg::N_CELLS].valid;
  assign out_item = '{
    out_alpha: (ctl_chain[mca_pkg::N_CELLS].keyed || ctl_chain[mca_pkg::N_CELLS].zero) ?
               '0 : div_chain[mca_pkg::N_CELLS].quo,
    keyed_out: ctl_chain[mca_pkg::N_CELLS].keyed
  };

endmodule

`default_nettype wire

@@ hdl/mca_checker.sv @@
`default_nettype none

module mca_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               start,
  input wire logic               busy,
  input wire mca_pkg::in_item_t  in_item,
  input wire logic               out_valid,
  input wire mca_pkg::out_item_t out_item
);

  // every accepted pixel yields a result after the fixed latency
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(mca_pkg::LATENCY) out_valid)
    else $error("accepted pixel produced no result");

  // no result without a pixel accepted at the matching edge
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, mca_pkg::LATENCY))
    else $error("result without accepted pixel");

  // transparent pixel is keyed and fully transparent
  a_transparent: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.pixel_alpha == '0) |-> ##(mca_pkg::LATENCY)
    (out_item.keyed_out && out_item.out_alpha == '0))
    else $error("transparent pixel not keyed");

  // a keyed result always carries zero alpha
  a_keyed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.keyed_out) |-> (out_item.out_alpha == '0))
    else $error("keyed result with nonzero alpha");

endmodule

bind matte_color_to_alpha_top mca_checker u_mca_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_item  (out_item)
);

`default_nettype wire

@@ tb/sv/alpha_key_checker.sv @@
`timescale 1ns / 100ps

module alpha_key_checker
  import mca_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic              busy,
  input  wire in_item_t          in_item,
  input  wire logic              out_valid,
  input  wire out_item_t         out_item,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  input  wire logic [DATA_W-1:0] prdata,
  input  wire logic              pready,
  output int                     fail_count,
  output int                     pending,
  output int                     reads_checked
);

  matte_t    matte_shadow;
  out_item_t alpha_due_q[$];
  int        n_fail = 0;
  int        n_due = 0;
  int        n_reads = 0;

  assign fail_count    = n_fail;
  assign pending       = n_due;
  assign reads_checked = n_reads;

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    n_fail++;
  endtask

  // exact integer form of the projection onto the matte direction
  function automatic out_item_t predict_alpha(input in_item_t px, input matte_t m);
    logic [63:0] msq;
    logic [63:0] dot;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] q;
    out_item_t   res;
    msq = 64'(m.blue) * 64'(m.blue) + 64'(m.green) * 64'(m.green)
        + 64'(m.red) * 64'(m.red);
    dot = 64'(px.pixel_blue) * 64'(m.blue) + 64'(px.pixel_green) * 64'(m.green)
        + 64'(px.pixel_red) * 64'(m.red);
    num = 64'd255 * dot;
    den = 64'(px.pixel_alpha) * msq;
    if (px.pixel_alpha == '0 ||
        (px.pixel_red == m.red && px.pixel_green == m.green &&
         px.pixel_blue == m.blue && px.pixel_alpha == m.alpha)) begin
      res.out_alpha = '0;
      res.keyed_out = 1'b1;
    end else begin
      if (den == 0 || num >= den)
        q = 0;
      else
        q = (64'd255 * (den - num)) / den;
      if (q > 64'd255)
        q = 64'd255;
      res.out_alpha = q[PIX_W-1:0];
      res.keyed_out = 1'b0;
    end
    return res;
  endfunction

  function automatic logic [PIX_W-1:0] matte_field(input matte_t m, input reg_idx_t idx);
    case (idx)
      REG_RED:   return m.red;
      REG_GREEN: return m.green;
      REG_BLUE:  return m.blue;
      default:   return m.alpha;
    endcase
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    reg_idx_t  idx;
    if (!rst_n) begin
      matte_shadow.red   <= MATTE_RED_RST;
      matte_shadow.green <= MATTE_GREEN_RST;
      matte_shadow.blue  <= MATTE_BLUE_RST;
      matte_shadow.alpha <= MATTE_ALPHA_RST;
      alpha_due_q.delete();
      n_due <= 0;
    end else begin
      idx = reg_idx_t'(paddr[ADDR_W-1:2]);
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (idx)
            REG_RED:   matte_shadow.red   <= pwdata[PIX_W-1:0];
            REG_GREEN: matte_shadow.green <= pwdata[PIX_W-1:0];
            REG_BLUE:  matte_shadow.blue  <= pwdata[PIX_W-1:0];
            REG_ALPHA: matte_shadow.alpha <= pwdata[PIX_W-1:0];
            default: ;
          endcase
        end else begin
          n_reads++;
          if (prdata[PIX_W-1:0] !== matte_field(matte_shadow, idx))
            report_mismatch($sformatf("register %s read %0d, expected %0d",
                            idx.name(), prdata[PIX_W-1:0], matte_field(matte_shadow, idx)));
        end
      end
      // older result leaves before a new pixel enters on the same edge
      if (out_valid) begin
        if (alpha_due_q.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending: alpha %0d keyed %0b",
                          out_item.out_alpha, out_item.keyed_out));
        end else begin
          want = alpha_due_q.pop_front();
          if (out_item.out_alpha !== want.out_alpha)
            report_mismatch($sformatf("out_alpha %0d, expected %0d",
                            out_item.out_alpha, want.out_alpha));
          if (out_item.keyed_out !== want.keyed_out)
            report_mismatch($sformatf("keyed_out %0b, expected %0b",
                            out_item.keyed_out, want.keyed_out));
        end
      end
      if (start && !busy)
        alpha_due_q.push_back(predict_alpha(in_item, matte_shadow));
      n_due <= alpha_due_q.size();
    end
  end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import mca_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 166;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  in_item_t          in_item = '0;
  logic              out_valid;
  out_item_t         out_item;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int     fail_count;
  int     pending;
  int     reads_checked;
  int     n_items = 0;
  int     n_settings = 0;
  int     stall_cycles = 0;
  matte_t cur_matte;

  always #5 clk = ~clk;

  matte_color_to_alpha_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  alpha_key_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_item       (in_item),
    .out_valid     (out_valid),
    .out_item      (out_item),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .fail_count    (fail_count),
    .pending       (pending),
    .reads_checked (reads_checked)
  );

  // cycles with no transfer on any port
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (psel && penable && pready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", stall_cycles);
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic in_item_t mk(input int b, input int g, input int r, input int a);
    in_item_t px;
    px.pixel_blue  = PIX_W'(b);
    px.pixel_green = PIX_W'(g);
    px.pixel_red   = PIX_W'(r);
    px.pixel_alpha = PIX_W'(a);
    return px;
  endfunction

  // matte channel scaled by alpha and a blend factor, plus a little noise
  function automatic int toward_matte(input int c, input int a, input int t);
    int v;
    v = (c * a * t) / (255 * 255) + $urandom_range(4) - 2;
    return (v < 0) ? 0 : (v > 255) ? 255 : v;
  endfunction

  function automatic in_item_t rand_pixel(input matte_t m);
    in_item_t px;
    int       sel;
    int       a;
    int       t;
    sel = $urandom_range(99);
    px = in_item_t'($urandom);
    if (sel < 8) begin
      px.pixel_alpha = '0;
    end else if (sel < 16) begin
      px = mk(m.blue, m.green, m.red, m.alpha);
    end else if (sel < 24) begin
      // one byte off the matte
      px = mk(m.blue, m.green, m.red, m.alpha);
      case ($urandom_range(3))
        0: px.pixel_blue  = px.pixel_blue  + PIX_W'($urandom_range(1, 255));
        1: px.pixel_green = px.pixel_green + PIX_W'($urandom_range(1, 255));
        2: px.pixel_red   = px.pixel_red   + PIX_W'($urandom_range(1, 255));
        default: px.pixel_alpha = px.pixel_alpha + PIX_W'($urandom_range(1, 255));
      endcase
    end else if (sel < 50) begin
      a = $urandom_range(1, 255);
      t = $urandom_range(255);
      px = mk(toward_matte(m.blue, a, t), toward_matte(m.green, a, t),
              toward_matte(m.red, a, t), a);
    end else if (sel < 75) begin
      a = $urandom_range(1, 255);
      px = mk($urandom_range(a), $urandom_range(a), $urandom_range(a), a);
    end
    return px;
  endfunction

  function automatic matte_t pick_matte(input int kind);
    matte_t m;
    m = matte_t'($urandom);
    case (kind)
      1: begin
        m.red   = $urandom_range(1) ? 8'hFF : 8'h00;
        m.green = $urandom_range(1) ? 8'hFF : 8'h00;
        m.blue  = $urandom_range(1) ? 8'hFF : 8'h00;
        m.alpha = $urandom_range(1) ? 8'hFF : 8'h00;
      end
      2: begin
        m.red   = '0;
        m.green = '0;
        m.blue  = '0;
        case ($urandom_range(2))
          0: m.red   = PIX_W'($urandom_range(1, 255));
          1: m.green = PIX_W'($urandom_range(1, 255));
          default: m.blue = PIX_W'($urandom_range(1, 255));
        endcase
      end
      3: begin
        m.red   = PIX_W'($urandom_range(3));
        m.green = PIX_W'($urandom_range(3));
        m.blue  = PIX_W'($urandom_range(3));
      end
      default: ;
    endcase
    return m;
  endfunction

  task automatic send(input in_item_t px, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start   <= 1'b0;
      in_item <= in_item_t'($urandom);
      @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= px;
    do @(posedge clk); while (busy);
    n_items++;
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic cfg_access(input logic wr, input reg_idx_t idx, input logic [PIX_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {2'(idx), 2'b00};
    pwdata  <= {(DATA_W - PIX_W)'($urandom), val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apply_matte(input matte_t m);
    drain();
    cfg_access(1'b1, REG_RED, m.red);
    cfg_access(1'b1, REG_GREEN, m.green);
    cfg_access(1'b1, REG_BLUE, m.blue);
    cfg_access(1'b1, REG_ALPHA, m.alpha);
    cfg_access(1'b0, REG_RED, '0);
    cfg_access(1'b0, REG_GREEN, '0);
    cfg_access(1'b0, REG_BLUE, '0);
    cfg_access(1'b0, REG_ALPHA, '0);
    cur_matte = m;
    n_settings++;
  endtask

  initial begin
    int idle_pct;
    int pause_at;
    cur_matte = '{red: MATTE_RED_RST, green: MATTE_GREEN_RST,
                  blue: MATTE_BLUE_RST, alpha: MATTE_ALPHA_RST};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default matte: transparent, exact match, near misses, clamps
    send(mk(0, 0, 0, 0), 0);
    send(mk(255, 255, 255, 0), 0);
    send(mk(150, 241, 255, 255), 0);
    send(mk(150, 241, 255, 254), 0);
    send(mk(151, 241, 255, 255), 0);
    send(mk(0, 0, 0, 255), 0);
    send(mk(255, 255, 255, 255), 0);
    send(mk(0, 0, 0, 1), 0);
    send(mk(255, 255, 255, 1), 0);
    send(mk(75, 120, 127, 128), 0);
    send(mk(255, 0, 0, 255), 0);
    send(mk(0, 255, 0, 255), 0);
    send(mk(0, 0, 255, 255), 0);
    send(mk(10, 20, 30, 200), 0);
    send(mk(200, 10, 5, 255), 0);

    // black matte: D is zero, so alpha is zero whether keyed or not
    apply_matte('{red: 8'd0, green: 8'd0, blue: 8'd0, alpha: 8'd0});
    send(mk(0, 0, 0, 0), 0);
    send(mk(0, 0, 0, 255), 0);
    send(mk(5, 5, 5, 100), 0);
    apply_matte('{red: 8'd0, green: 8'd0, blue: 8'd0, alpha: 8'd255});
    send(mk(0, 0, 0, 255), 0);
    send(mk(1, 0, 0, 255), 0);

    apply_matte('{red: 8'd255, green: 8'd255, blue: 8'd255, alpha: 8'd255});
    send(mk(255, 255, 255, 255), 0);
    send(mk(128, 128, 128, 128), 0);
    send(mk(0, 0, 0, 255), 0);
    send(mk(255, 255, 255, 254), 0);

    for (int phase = 0; phase < PHASES; phase++) begin
      case ((phase + phase / 4) % 4)
        0: idle_pct = 0;
        1: idle_pct = 85;
        2: idle_pct = 0;
        default: idle_pct = 27;
      endcase
      apply_matte(pick_matte(phase % 4));
      pause_at = $urandom_range(10, PHASE_ITEMS - 10);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // hold the sender until the pipeline runs dry
        if (k == pause_at)
          drain();
        send(rand_pixel(cur_matte), idle_pct);
      end
    end

    drain();
    repeat (LATENCY + 4) @(posedge clk);
    $display("Ran %0d pixels under %0d matte settings, sender gaps of 0, 27 and 85 percent",
             n_items, n_settings);
    $display("Keyed, black-matte, clamped and projected pixels seen; %0d register reads checked",
             reads_checked);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/mca_pkg.sv
hdl/mca_prep.sv
hdl/mca_div_cell.sv
hdl/matte_color_to_alpha_top.sv
hdl/mca_checker.sv
tb/sv/alpha_key_checker.sv
tb/sv/testbench.sv
